[design/tfs_pkg.sv]
// Shared types and constants for the triangle flat split setup block.
`default_nettype none
package tfs_pkg;

    localparam int CW = 16;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [CW-1:0]        t_umag;
    typedef logic [2*CW-1:0]      t_prod;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_coord x3;
        t_coord y3;
    } t_vtx;

    typedef struct packed {
        t_vtx v;
        logic neg;
        logic degen;
    } t_ctl;

    typedef struct packed {
        t_umag rem;
        t_umag low;
        t_umag den;
    } t_div;

    typedef struct packed {
        t_ctl ctl;
        t_div div;
    } t_cell;

endpackage
`default_nettype wire

[design/tfs_in_if.sv]
// Request channel carrying the three unsorted vertices.
`default_nettype none
interface tfs_in_if;
    import tfs_pkg::*;

    logic   valid;
    logic   ready;
    t_coord in_x_a;
    t_coord in_y_a;
    t_coord in_x_b;
    t_coord in_y_b;
    t_coord in_x_c;
    t_coord in_y_c;

    modport source (
        output valid, in_x_a, in_y_a, in_x_b, in_y_b, in_x_c, in_y_c,
        input  ready
    );
    modport sink (
        input  valid, in_x_a, in_y_a, in_x_b, in_y_b, in_x_c, in_y_c,
        output ready
    );
endinterface
`default_nettype wire

[design/tfs_out_if.sv]
// Result channel carrying the sorted vertices and the split point.
`default_nettype none
interface tfs_out_if;
    import tfs_pkg::*;

    logic   valid;
    logic   ready;
    t_coord top_x;
    t_coord top_y;
    t_coord middle_x;
    t_coord middle_y;
    t_coord bottom_x;
    t_coord bottom_y;
    t_coord split_x;
    t_coord split_y;
    logic   degenerate;

    modport source (
        output valid, top_x, top_y, middle_x, middle_y, bottom_x, bottom_y,
               split_x, split_y, degenerate,
        input  ready
    );
    modport sink (
        input  valid, top_x, top_y, middle_x, middle_y, bottom_x, bottom_y,
               split_x, split_y, degenerate,
        output ready
    );
endinterface
`default_nettype wire

[design/tfs_sort.sv]
// Three-compare sort network on y, one registered stage.
`default_nettype none
module tfs_sort (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tfs_pkg::t_vtx i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tfs_pkg::t_vtx o_data
);
    import tfs_pkg::*;

    logic r_valid;
    t_vtx r_data;
    t_vtx n_data;
    t_vtx s0;
    t_vtx s1;

    always_comb begin
        s0 = i_data;
        if ($signed(i_data.y1) > $signed(i_data.y2)) begin
            s0.x1 = i_data.x2;
            s0.y1 = i_data.y2;
            s0.x2 = i_data.x1;
            s0.y2 = i_data.y1;
        end
        s1 = s0;
        if ($signed(s0.y2) > $signed(s0.y3)) begin
            s1.x2 = s0.x3;
            s1.y2 = s0.y3;
            s1.x3 = s0.x2;
            s1.y3 = s0.y2;
        end
        n_data = s1;
        if ($signed(s1.y1) > $signed(s1.y2)) begin
            n_data.x1 = s1.x2;
            n_data.y1 = s1.y2;
            n_data.x2 = s1.x1;
            n_data.y2 = s1.y1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

[design/tfs_mul.sv]
// Edge deltas and the dy * |dx| product that feeds the divider chain.
`default_nettype none
module tfs_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tfs_pkg::t_vtx  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tfs_pkg::t_cell o_data
);
    import tfs_pkg::*;

    logic        r_valid;
    t_cell       r_data;
    t_cell       n_data;
    logic [CW:0] dy;
    logic [CW:0] den;
    logic [CW:0] dx;
    logic [CW:0] mag;
    t_prod       prod;

    always_comb begin
        dy   = {i_data.y2[CW-1], i_data.y2} - {i_data.y1[CW-1], i_data.y1};
        den  = {i_data.y3[CW-1], i_data.y3} - {i_data.y1[CW-1], i_data.y1};
        dx   = {i_data.x3[CW-1], i_data.x3} - {i_data.x1[CW-1], i_data.x1};
        mag  = dx[CW] ? (~dx + 1'b1) : dx;
        prod = dy[CW-1:0] * mag[CW-1:0];
        n_data.ctl.v     = i_data;
        n_data.ctl.neg   = dx[CW];
        n_data.ctl.degen = (i_data.y3 == i_data.y1);
        n_data.div.rem   = prod[2*CW-1:CW];
        n_data.div.low   = prod[CW-1:0];
        n_data.div.den   = den[CW-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

[design/tfs_div_cell.sv]
// One restoring-division step: shifts in a dividend bit, emits one quotient bit.
`default_nettype none
module tfs_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tfs_pkg::t_cell i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tfs_pkg::t_cell o_data
);
    import tfs_pkg::*;

    logic        r_valid;
    t_cell       r_data;
    t_cell       n_data;
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
        trial = {i_data.div.rem, i_data.div.low[CW-1]};
        diff  = trial - {1'b0, i_data.div.den};
        ge    = (trial >= {1'b0, i_data.div.den});
        n_data         = i_data;
        n_data.div.rem = ge ? diff[CW-1:0] : trial[CW-1:0];
        n_data.div.low = {i_data.div.low[CW-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

[design/triangle_flat_split_setup_core.sv]
// Triangle setup top level: sort, product, divider chain and split output.
// Takes one triangle request per cycle while the result side does not stall, and
// returns one result per request, in order. A request passes through the y-sort
// register, the register for the edge deltas and dy*|dx| product, the chain of 16
// restoring-division cells (one quotient bit per cell) and the output register,
// which takes the split-point add. Every stage has its own valid bit
// and a request moves on whenever the next stage is free, so gaps in the flow
// close up and a held result stops new requests only once all 19 stages are full.
// Quotients truncate toward zero; a flat triangle (top y equal to bottom y)
// sets degenerate and returns the top x as split x.
`default_nettype none
module triangle_flat_split_setup_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfs_in_if.sink    i_in,
    tfs_out_if.source o_out
);
    import tfs_pkg::*;

    t_vtx  w_in_vtx;
    wire   w_sort_valid;
    wire   w_sort_ready;
    t_vtx  w_sort_data;
    wire   [CW:0] w_valid;
    wire   [CW:0] w_ready;
    wire   t_cell w_cell [0:CW];

    logic  r_valid;
    logic  out_free;
    t_coord r_top_x;
    t_coord r_top_y;
    t_coord r_mid_x;
    t_coord r_mid_y;
    t_coord r_bot_x;
    t_coord r_bot_y;
    t_coord r_split_x;
    logic   r_degen;
    t_coord n_split_x;
    t_ctl   last_ctl;
    t_umag  quot;

    assign w_in_vtx.x1 = i_in.in_x_a;
    assign w_in_vtx.y1 = i_in.in_y_a;
    assign w_in_vtx.x2 = i_in.in_x_b;
    assign w_in_vtx.y2 = i_in.in_y_b;
    assign w_in_vtx.x3 = i_in.in_x_c;
    assign w_in_vtx.y3 = i_in.in_y_c;

    tfs_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (w_in_vtx),
        .o_valid (w_sort_valid),
        .i_ready (w_sort_ready),
        .o_data  (w_sort_data)
    );

    tfs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sort_valid),
        .o_ready (w_sort_ready),
        .i_data  (w_sort_data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_cell[0])
    );

    for (genvar g = 0; g < CW; g++) begin : g_div
        tfs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_cell[g+1])
        );
    end

    assign last_ctl = w_cell[CW].ctl;
    assign quot     = w_cell[CW].div.low;

    always_comb begin
        if (last_ctl.degen) begin
            n_split_x = last_ctl.v.x1;
        end else if (last_ctl.neg) begin
            n_split_x = last_ctl.v.x1 - quot;
        end else begin
            n_split_x = last_ctl.v.x1 + quot;
        end
    end

    assign out_free    = !r_valid || o_out.ready;
    assign w_ready[CW] = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= w_valid[CW];
        end
        if (out_free && w_valid[CW]) begin
            r_top_x   <= last_ctl.v.x1;
            r_top_y   <= last_ctl.v.y1;
            r_mid_x   <= last_ctl.v.x2;
            r_mid_y   <= last_ctl.v.y2;
            r_bot_x   <= last_ctl.v.x3;
            r_bot_y   <= last_ctl.v.y3;
            r_split_x <= n_split_x;
            r_degen   <= last_ctl.degen;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.top_x      = r_top_x;
    assign o_out.top_y      = r_top_y;
    assign o_out.middle_x   = r_mid_x;
    assign o_out.middle_y   = r_mid_y;
    assign o_out.bottom_x   = r_bot_x;
    assign o_out.bottom_y   = r_bot_y;
    assign o_out.split_x    = r_split_x;
    assign o_out.split_y    = r_mid_y;
    assign o_out.degenerate = r_degen;
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for triangle_flat_split_setup_core: directed table, then random.
`default_nettype none
module tb;
    import tfs_pkg::*;

    localparam int NUM_RANDOM  = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 29;

    typedef struct packed {
        t_coord xa;
        t_coord ya;
        t_coord xb;
        t_coord yb;
        t_coord xc;
        t_coord yc;
    } t_tri;

    typedef struct packed {
        t_coord top_x;
        t_coord top_y;
        t_coord middle_x;
        t_coord middle_y;
        t_coord bottom_x;
        t_coord bottom_y;
        t_coord split_x;
        t_coord split_y;
        logic   degenerate;
    } t_setup;

    typedef struct packed {
        t_tri   shape;
        bit     typed;
        t_setup res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tfs_in_if  in_ch ();
    tfs_out_if out_ch ();

    triangle_flat_split_setup_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_setup pending_setups[$];
    int     error_count;
    int     checked_count;
    int     sent_count;
    int     flat_count;
    int     cycle_count;
    bit     steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_setups.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Sort by y (stable), then split the long edge at the middle height.
    function automatic t_setup setup_triangle(t_tri t);
        longint x1, y1, x2, y2, x3, y3, tmp;
        longint dy, den, dx, mag, q, sx;
        t_setup r;
        x1 = longint'(t.xa); y1 = longint'(t.ya);
        x2 = longint'(t.xb); y2 = longint'(t.yb);
        x3 = longint'(t.xc); y3 = longint'(t.yc);
        if (y1 > y2) begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        if (y2 > y3) begin
            tmp = x2; x2 = x3; x3 = tmp;
            tmp = y2; y2 = y3; y3 = tmp;
        end
        if (y1 > y2) begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        r.degenerate = (y3 == y1);
        if (r.degenerate) begin
            sx = x1;
        end else begin
            dy  = y2 - y1;
            den = y3 - y1;
            dx  = x3 - x1;
            mag = (dx < 0) ? -dx : dx;
            q   = (dy * mag) / den;
            sx  = (dx < 0) ? x1 - q : x1 + q;
        end
        r.top_x    = t_coord'(x1);
        r.top_y    = t_coord'(y1);
        r.middle_x = t_coord'(x2);
        r.middle_y = t_coord'(y2);
        r.bottom_x = t_coord'(x3);
        r.bottom_y = t_coord'(y3);
        r.split_x  = t_coord'(sx);
        r.split_y  = t_coord'(y2);
        return r;
    endfunction

    function automatic t_coord pick_corner();
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    function automatic t_tri random_triangle();
        t_tri   t;
        t_coord ylo, yhi;
        int     kind;
        kind = $urandom_range(99);
        t = t_tri'({$urandom, $urandom, $urandom});
        if (kind >= 50 && kind < 70) begin
            t.xa = t_coord'($urandom_range(64) - 32);
            t.ya = t_coord'($urandom_range(64) - 32);
            t.xb = t_coord'($urandom_range(64) - 32);
            t.yb = t_coord'($urandom_range(64) - 32);
            t.xc = t_coord'($urandom_range(64) - 32);
            t.yc = t_coord'($urandom_range(64) - 32);
        end else if (kind >= 70 && kind < 85) begin
            // y drawn from two values: ties on top, bottom or all three
            ylo  = t_coord'($urandom);
            yhi  = ($urandom_range(3) == 0) ? ylo : t_coord'($urandom);
            t.ya = $urandom_range(1) ? ylo : yhi;
            t.yb = $urandom_range(1) ? ylo : yhi;
            t.yc = $urandom_range(1) ? ylo : yhi;
        end else if (kind >= 85) begin
            t.xa = pick_corner(); t.ya = pick_corner();
            t.xb = pick_corner(); t.yb = pick_corner();
            t.xc = pick_corner(); t.yc = pick_corner();
        end
        return t;
    endfunction

    task automatic send_triangle(t_tri t, t_setup want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.in_x_a <= t.xa;
        in_ch.in_y_a <= t.ya;
        in_ch.in_x_b <= t.xb;
        in_ch.in_y_b <= t.yb;
        in_ch.in_x_c <= t.xc;
        in_ch.in_y_c <= t.yc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_setups.push_back(want);
        sent_count++;
        if (want.degenerate) flat_count++;
        @(negedge i_clk);
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_setup got, want;
        string  bad;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.top_x, out_ch.top_y, out_ch.middle_x, out_ch.middle_y,
                    out_ch.bottom_x, out_ch.bottom_y, out_ch.split_x, out_ch.split_y,
                    out_ch.degenerate};
            if (pending_setups.size() == 0) begin
                note_error($sformatf("result with no request outstanding: %p", got));
            end else begin
                want = pending_setups.pop_front();
                checked_count++;
                bad = "";
                if (got.top_x !== want.top_x)           bad = {bad, " top_x"};
                if (got.top_y !== want.top_y)           bad = {bad, " top_y"};
                if (got.middle_x !== want.middle_x)     bad = {bad, " middle_x"};
                if (got.middle_y !== want.middle_y)     bad = {bad, " middle_y"};
                if (got.bottom_x !== want.bottom_x)     bad = {bad, " bottom_x"};
                if (got.bottom_y !== want.bottom_y)     bad = {bad, " bottom_y"};
                if (got.split_x !== want.split_x)       bad = {bad, " split_x"};
                if (got.split_y !== want.split_y)       bad = {bad, " split_y"};
                if (got.degenerate !== want.degenerate) bad = {bad, " degenerate"};
                if (bad != "")
                    note_error($sformatf("result %0d wrong:%s\n  exp %p\n  got %p",
                                         checked_count, bad, want, got));
            end
        end
    end

    t_row directed_rows[14];

    initial begin
        t_tri t;
        error_count   = 0;
        checked_count = 0;
        sent_count    = 0;
        flat_count    = 0;
        cycle_count   = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_x_a  = '0;
        in_ch.in_y_a  = '0;
        in_ch.in_x_b  = '0;
        in_ch.in_y_b  = '0;
        in_ch.in_x_c  = '0;
        in_ch.in_y_c  = '0;

        directed_rows = '{
            // all at origin: flat
            '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1}},
            // flat, equal y keeps input order
            '{'{10, 5, 20, 5, 30, 5}, 1'b1, '{10, 5, 20, 5, 30, 5, 10, 5, 1'b1}},
            // full span both axes
            '{'{-32768, -32768, 32767, 32767, 0, 0}, 1'b1,
              '{-32768, -32768, 0, 0, 32767, 32767, 0, 0, 1'b0}},
            '{'{32767, 32767, 32767, 32767, 32767, 32767}, 1'b1,
              '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1}},
            '{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b1,
              '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1}},
            // reversed input order
            '{'{5, 300, -7, 200, 100, 100}, 1'b0, '{default: 0}},
            // lowest vertex second, then third
            '{'{0, 10, 5, 0, 7, 20}, 1'b0, '{default: 0}},
            '{'{0, 10, 5, 20, 7, 0}, 1'b0, '{default: 0}},
            // flat top, flat bottom
            '{'{0, 0, 40, 0, 16, 32}, 1'b0, '{default: 0}},
            '{'{0, 0, 40, 32, 16, 32}, 1'b0, '{default: 0}},
            // quotient truncation, negative and positive dx
            '{'{0, 0, 99, 1, -3, 2}, 1'b0, '{default: 0}},
            '{'{0, 0, 99, 1, 3, 2}, 1'b0, '{default: 0}},
            '{'{21845, -21846, -21846, 21845, -1, -1}, 1'b0, '{default: 0}},
            '{'{-32768, 32767, 32767, -32768, -32768, 0}, 1'b0, '{default: 0}}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            t = directed_rows[i].shape;
            send_triangle(t, directed_rows[i].typed ? directed_rows[i].res
                                                    : setup_triangle(t));
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            steady = (n >= 400 && n < 600);
            t = random_triangle();
            send_triangle(t, setup_triangle(t));
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending_setups.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d triangles (%0d directed, %0d flat), checked %0d results",
                 sent_count, $size(directed_rows), flat_count, checked_count);
        $display("mismatches: %0d, cycles: %0d", error_count, cycle_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
